FILE: design/bfm_pkg.sv
`default_nettype none

package bfm_pkg;

  // configuration port
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_BITS-1:0] RESET_SIZE = 11'd1024;

  // width of the reported centre position
  localparam int POS_BITS = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // per-pixel control that follows the data down the pipeline
  typedef struct packed {
    logic                emit;
    logic                last;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } tag_t;

endpackage

`default_nettype wire

FILE: design/bfm_pixel_if.sv
`default_nettype none

interface bfm_pixel_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

FILE: design/bfm_result_if.sv
`default_nettype none

interface bfm_result_if #(
  parameter int PIXEL_BITS = 16
);
  import bfm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] mean_value;
  logic [POS_BITS-1:0]   centre_row;
  logic [POS_BITS-1:0]   centre_col;
  logic                  frame_last;

  modport source (
    output valid, output mean_value, output centre_row, output centre_col,
    output frame_last, input ready
  );
  modport sink (
    input valid, input mean_value, input centre_row, input centre_col,
    input frame_last, output ready
  );
endinterface

`default_nettype wire

FILE: design/bfm_pos_ctrl.sv
`default_nettype none

module bfm_pos_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bfm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bfm_pkg::CFG_BITS-1:0]   cfg_wdata,
  input  wire logic                           advance,
  output logic      [COL_BITS-1:0]            col,
  output bfm_pkg::tag_t                       tag
);
  import bfm_pkg::*;

  localparam int DIM_BITS = ((COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS) + 1;
  localparam int CMP_BITS = (DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS;
  localparam logic [CMP_BITS-1:0] MAX_W = CMP_BITS'(MAX_WIDTH);
  localparam logic [CMP_BITS-1:0] MAX_H = CMP_BITS'(MAX_HEIGHT);
  localparam logic [CMP_BITS-1:0] MIN_SIZE = CMP_BITS'(3);

  logic [COL_BITS:0]   size_w;
  logic [ROW_BITS:0]   size_h;
  logic [COL_BITS-1:0] col_count;
  logic [ROW_BITS-1:0] row_count;

  logic                wrap_pre;
  logic [COL_BITS-1:0] c;
  logic [ROW_BITS:0]   row_pre;
  logic [ROW_BITS-1:0] r;
  logic [COL_BITS:0]   col_inc;
  logic [ROW_BITS:0]   row_inc;
  logic                row_end;

  // out-of-range sizes act as the nearest limit
  function automatic logic [CMP_BITS-1:0] clamp_size(
    input logic [CFG_BITS-1:0] v,
    input logic [CMP_BITS-1:0] maxv
  );
    logic [CMP_BITS-1:0] ext;
    ext = CMP_BITS'(v);
    if (ext < MIN_SIZE) begin
      return MIN_SIZE;
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  // position of this pixel, after any wrap left by a size change
  always_comb begin
    wrap_pre = {1'b0, col_count} >= size_w;
    c        = wrap_pre ? '0 : col_count;
    row_pre  = wrap_pre ? ({1'b0, row_count} + (ROW_BITS+1)'(1)) : {1'b0, row_count};
    r        = (row_pre >= size_h) ? '0 : row_pre[ROW_BITS-1:0];
    col_inc  = {1'b0, c} + (COL_BITS+1)'(1);
    row_inc  = {1'b0, r} + (ROW_BITS+1)'(1);
    row_end  = col_inc >= size_w;
  end

  // result tag for the window centred one row up and one column left
  always_comb begin
    col      = c;
    tag.emit = (c >= COL_BITS'(2)) && (r >= ROW_BITS'(2));
    tag.last = ({1'b0, r} == size_h - (ROW_BITS+1)'(1)) &&
               ({1'b0, c} == size_w - (COL_BITS+1)'(1));
    tag.row  = POS_BITS'(r - ROW_BITS'(1));
    tag.col  = POS_BITS'(c - COL_BITS'(1));
  end

  // size registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      size_w    <= (COL_BITS+1)'(clamp_size(RESET_SIZE, MAX_W));
      size_h    <= (ROW_BITS+1)'(clamp_size(RESET_SIZE, MAX_H));
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH: begin
            size_w <= (COL_BITS+1)'(clamp_size(cfg_wdata, MAX_W));
          end
          REG_IMAGE_HEIGHT: begin
            size_h <= (ROW_BITS+1)'(clamp_size(cfg_wdata, MAX_H));
          end
        endcase
      end
      if (advance) begin
        if (row_end) begin
          col_count <= '0;
          row_count <= (row_inc >= size_h) ? '0 : row_inc[ROW_BITS-1:0];
        end else begin
          col_count <= col_inc[COL_BITS-1:0];
          row_count <= r;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/bfm_line_store.sv
`default_nettype none

module bfm_line_store #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 32,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/bfm_mean.sv
`default_nettype none

module bfm_mean #(
  parameter int PIXEL_BITS = 16,
  localparam int CS_BITS   = PIXEL_BITS + 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CS_BITS-1:0]    col_a,
  input  wire logic [CS_BITS-1:0]    col_b,
  input  wire logic [CS_BITS-1:0]    col_c,
  input  wire bfm_pkg::tag_t         in_tag,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIXEL_BITS-1:0] mean,
  output bfm_pkg::tag_t              out_tag
);
  import bfm_pkg::*;

  // floor(x / 9) as (x * ceil(2^K / 9)) >> K, exact for x below 2^(K-3)
  localparam int SUM_BITS = PIXEL_BITS + 4;
  localparam int K        = SUM_BITS + 4;
  localparam int XL       = SUM_BITS / 2;
  localparam int XH       = SUM_BITS - XL;
  localparam int PROD_W   = SUM_BITS + K;
  localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'd8) / 64'd9;
  localparam logic [K-1:0] RECIP = RECIP_L[K-1:0];

  logic                v_sum, v_prod;
  logic                free_sum, free_prod, free_out;
  logic [SUM_BITS-1:0] sum;
  tag_t                tag_sum, tag_prod;
  logic [XL+K-1:0]     p_lo;
  logic [XH+K-1:0]     p_hi;
  logic [PROD_W-1:0]   q_full;

  assign free_out  = !out_valid || out_ready;
  assign free_prod = !v_prod || free_out;
  assign free_sum  = !v_sum || free_prod;
  assign in_ready  = free_sum;

  // recombine the two partial products
  assign q_full = {p_hi, {XL{1'b0}}} + PROD_W'(p_lo);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v_sum     <= 1'b0;
      v_prod    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free_sum) begin
        v_sum <= in_valid;
      end
      if (free_prod) begin
        v_prod <= v_sum;
      end
      if (free_out) begin
        out_valid <= v_prod;
      end
    end
  end

  // window sum, split multiply, quotient
  always_ff @(posedge clk) begin
    if (free_sum && in_valid) begin
      sum     <= SUM_BITS'(col_a) + SUM_BITS'(col_b) + SUM_BITS'(col_c);
      tag_sum <= in_tag;
    end
    if (free_prod && v_sum) begin
      p_lo     <= {{K{1'b0}}, sum[XL-1:0]} * {{XL{1'b0}}, RECIP};
      p_hi     <= {{K{1'b0}}, sum[SUM_BITS-1:XL]} * {{XH{1'b0}}, RECIP};
      tag_prod <= tag_sum;
    end
    if (free_out && v_prod) begin
      mean    <= q_full[K +: PIXEL_BITS];
      out_tag <= tag_prod;
    end
  end

endmodule

`default_nettype wire

FILE: design/box_filter_3x3_mean_top.sv
`default_nettype none

// 3x3 box mean filter over a raster-order pixel stream.
// pixels: one unsigned pixel per transaction, row by row, frame after frame.
// results: one transaction per interior pixel, carrying the truncated mean of
//   its 3x3 neighbourhood, its row and column, and a flag on the final result
//   of the frame. Border pixels produce nothing.
// cfg_we/cfg_index/cfg_wdata: image_width (index 0) and image_height (index 1),
//   both 1024 after reset; values outside 3..max act as the nearest limit.
//   Write them only while no pixel is in flight.
// Throughput: one pixel per cycle unless results stall, set by the line
//   store's read and write each cycle (two rows share one word per column).
// Path: the line store read, the window update and snapshot, then the sum,
//   multiply and quotient registers of the mean unit lead to a result.
// Reset: sizes, position counters and the window clear at once; the line store
//   holds no reset value and is filled by the first two rows of a frame.
// Stall: a waiting result holds its output register; pixels keep being taken
//   while bubbles remain in the pipeline, and ready drops once it is full.
module box_filter_3x3_mean_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [bfm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bfm_pkg::CFG_BITS-1:0]     cfg_wdata,
  bfm_pixel_if.sink                             pixels,
  bfm_result_if.source                          results
);
  import bfm_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int CS_BITS  = PIXEL_BITS + 2;

  logic                    accept;
  logic [COL_BITS-1:0]     rd_col;
  tag_t                    rd_tag;

  // stage 1: line store data is ready
  logic                    v1;
  logic [PIXEL_BITS-1:0]   px1;
  logic [COL_BITS-1:0]     col1;
  tag_t                    tag1;
  logic [2*PIXEL_BITS-1:0] rd_data;
  logic [PIXEL_BITS-1:0]   top_px, mid_px;
  logic [CS_BITS-1:0]      new_col;
  logic                    go1, free1;

  // window held as three column sums, oldest first
  logic [CS_BITS-1:0]      cs0, cs1, cs2;

  // stage 2: snapshot handed to the mean unit
  logic                    v2;
  logic [CS_BITS-1:0]      s2_a, s2_b, s2_c;
  tag_t                    tag2;
  logic                    mean_ready;
  tag_t                    out_tag;

  assign accept       = pixels.valid && pixels.ready;
  assign go1          = v1 && (!tag1.emit || !v2 || mean_ready);
  assign free1        = !v1 || go1;
  assign pixels.ready = free1;

  // entry layout: older row in the upper half, newer row in the lower half
  assign top_px  = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_px  = rd_data[PIXEL_BITS-1:0];
  assign new_col = CS_BITS'(top_px) + CS_BITS'(mid_px) + CS_BITS'(px1);

  bfm_pos_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (accept),
    .col       (rd_col),
    .tag       (rd_tag)
  );

  // consecutive pixels never share a column, so the write-back of one
  // always lands before a later pixel reads that column again
  bfm_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2*PIXEL_BITS)
  ) u_lines (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_col),
    .rd_data (rd_data),
    .wr_en   (go1),
    .wr_addr (col1),
    .wr_data ({mid_px, px1})
  );

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      cs0 <= '0;
      cs1 <= '0;
      cs2 <= '0;
    end else begin
      if (free1) begin
        v1 <= pixels.valid;
      end
      if (go1 && tag1.emit) begin
        v2 <= 1'b1;
      end else if (mean_ready) begin
        v2 <= 1'b0;
      end
      if (go1) begin
        cs0 <= cs1;
        cs1 <= cs2;
        cs2 <= new_col;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px1  <= pixels.pixel;
      col1 <= rd_col;
      tag1 <= rd_tag;
    end
    if (go1 && tag1.emit) begin
      s2_a <= cs1;
      s2_b <= cs2;
      s2_c <= new_col;
      tag2 <= tag1;
    end
  end

  bfm_mean #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mean (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (mean_ready),
    .col_a     (s2_a),
    .col_b     (s2_b),
    .col_c     (s2_c),
    .in_tag    (tag2),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .mean      (results.mean_value),
    .out_tag   (out_tag)
  );

  assign results.centre_row = out_tag.row;
  assign results.centre_col = out_tag.col;
  assign results.frame_last = out_tag.last;

  // a new read never targets the column still waiting for write-back
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (accept && v1) |-> (rd_col != col1))
    else $error("line store read overlaps pending write-back");

  // results never name a centre in the first row or the first column
  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.centre_row != '0 && results.centre_col != '0))
    else $error("result for a border pixel");

  // only emitting pixels reach the mean unit
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    v2 |-> tag2.emit)
    else $error("non-emitting pixel handed to mean unit");

  // a window snapshot is taken only when the pixel leaves stage 1
  a_snapshot_on_go: assert property (@(posedge clk) disable iff (rst)
    (v1 && tag1.emit && v2 && !mean_ready) |=> ($stable(s2_a) && $stable(s2_c)))
    else $error("window snapshot overwritten while stalled");

endmodule

`default_nettype wire
